// ===== sv/baud_divisor_search_macros.svh =====
// Assertion macros shared by the baud divisor search RTL
`ifndef BAUD_DIVISOR_SEARCH_MACROS_SVH
`define BAUD_DIVISOR_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BDS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bds_pkg.sv =====
// Types and constants of the baud divisor search
package bds_pkg;

  localparam int CLOCK_W        = 30;
  localparam int RATE_W         = 20;
  localparam int SEL_W          = 2;
  localparam int DIV_W          = 8;
  localparam int ERR_W          = 15;
  localparam int NUM_PRESCALERS = 4;
  localparam int DIVISOR_LIMIT  = 256;

  localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(16000000);
  localparam logic signed [ERR_W-1:0] UNUSABLE_ERR = ERR_W'(10000);

  // clock / (16 * rate) gives twice clock / (32 * rate)
  localparam int FRAC_W     = 4;
  localparam int X_W        = CLOCK_W - FRAC_W;
  localparam int REM_W      = 32;
  localparam int LIM_W      = DIV_W + 2;
  localparam int M_W        = DIV_W + 1;
  localparam int PROD_W     = M_W + RATE_W;
  localparam int BASE_SHIFT = 5;
  localparam int SHIFT_MAX  = BASE_SHIFT + 2 * (NUM_PRESCALERS - 1);
  localparam int DF_W       = PROD_W + SHIFT_MAX;
  localparam int D_W        = 31;
  localparam int MAG_W      = 29;
  localparam int CMP_W      = MAG_W + D_W;
  localparam int SCALE      = 20000;
  localparam int SCALE_W    = 15;
  localparam int NUM_W      = MAG_W + SCALE_W;
  localparam int ERR_Q_W    = 12;

  typedef struct packed {
    logic             found;
    logic [SEL_W-1:0] sel;
    logic [DIV_W-1:0] div;
    logic             neg;
  } res_tag_t;

  // One restoring division step works on this word
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [REM_W-1:0] dvs;
    logic [X_W-1:0]   x;
    res_tag_t         tag;
  } div_t;

  typedef struct packed {
    logic             ok;
    logic [DIV_W-1:0] div;
    logic [MAG_W-1:0] mag;
    logic [D_W-1:0]   d;
    logic             neg;
  } cand_t;

  typedef struct packed {
    logic             found;
    logic [SEL_W-1:0] sel;
    logic [DIV_W-1:0] div;
    logic [MAG_W-1:0] mag;
    logic [D_W-1:0]   d;
    logic             neg;
  } best_t;

  typedef struct packed {
    cand_t [NUM_PRESCALERS-1:0] cands;
    best_t                      best;
  } pick_t;

endpackage

// ===== sv/bds_if.sv =====
// Request and result channels of the baud divisor search
interface bds_in_if;
  import bds_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] bit_rate;

  modport source (output valid, output bit_rate, input ready);
  modport sink (input valid, input bit_rate, output ready);
endinterface

interface bds_out_if;
  import bds_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    usable;
  logic [SEL_W-1:0]        clock_select;
  logic [DIV_W-1:0]        divisor;
  logic signed [ERR_W-1:0] error_hundredths;

  modport source (output valid, output usable, output clock_select, output divisor,
                  output error_hundredths, input ready);
  modport sink (input valid, input usable, input clock_select, input divisor,
                input error_hundredths, output ready);
endinterface

// ===== sv/bds_div_cell.sv =====
// One restoring division step: one quotient bit per cell
module bds_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  bds_pkg::div_t data_i,
  input  logic          en_i,
  output logic          en_o,
  output logic          valid_o,
  output bds_pkg::div_t data_o
);
  import bds_pkg::*;

  logic             v_q;
  div_t             data_q, data_d;
  logic [REM_W:0]   sh, diff;
  logic             ge;

  assign en_o = !v_q || en_i;

  always_comb begin
    sh     = {data_i.rem, data_i.x[X_W-1]};
    diff   = sh - {1'b0, data_i.dvs};
    ge     = sh >= {1'b0, data_i.dvs};
    data_d = data_i;
    data_d.rem = ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
    data_d.x   = {data_i.x[X_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;
endmodule

// ===== sv/bds_cand.sv =====
// Divisor, rounding and error magnitude for every prescaler, two stages
module bds_cand (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bds_pkg::CLOCK_W-1:0]  clock_i,
  input  logic                         valid_i,
  input  bds_pkg::div_t                data_i,
  input  logic                         en_i,
  output logic                         en_o,
  output logic                         valid_o,
  output bds_pkg::pick_t               data_o
);
  import bds_pkg::*;

  logic                                   v1_q, v2_q, en2;
  logic [NUM_PRESCALERS-1:0]              ok_q, ok_d;
  logic [NUM_PRESCALERS-1:0][DIV_W-1:0]   div_q, div_d;
  logic [NUM_PRESCALERS-1:0][PROD_W-1:0]  prod_q, prod_d;
  pick_t                                  pick_q, pick_d;

  assign en2  = !v2_q || en_i;
  assign en_o = !v1_q || en2;

  // Stage one: round to nearest with ties to an even divisor, then (N+1)*rate
  always_comb begin
    logic [X_W-1:0]   t;
    logic [X_W-1:0]   lowm;
    logic [X_W-2:0]   q;
    logic             ex;
    logic             dec;
    logic [LIM_W-1:0] dv;
    for (int n = 0; n < NUM_PRESCALERS; n++) begin
      t    = data_i.x >> (2 * n);
      lowm = ~({X_W{1'b1}} << (2 * n));
      ex   = (data_i.rem == '0) && (clock_i[FRAC_W-1:0] == '0) && ((data_i.x & lowm) == '0);
      q    = t[X_W-1:1];
      dec  = !t[0] || (ex && q[0]);
      dv   = {1'b0, q[DIV_W:0]} - LIM_W'(dec);
      ok_d[n]   = (data_i.dvs != '0) && ((q >> (DIV_W + 1)) == '0) && (dv != '0) &&
                  (dv < LIM_W'(DIVISOR_LIMIT));
      div_d[n]  = dv[DIV_W-1:0];
      prod_d[n] = PROD_W'(dv[M_W-1:0] + M_W'(1)) * PROD_W'(data_i.dvs[RATE_W-1:0]);
    end
  end

  // Stage two: scale by 32 * 4^n and take the distance to the clock
  always_comb begin
    logic [DF_W-1:0] dfull;
    logic [D_W-1:0]  dd;
    logic [D_W-1:0]  ck;
    ck = D_W'(clock_i);
    pick_d = '0;
    for (int n = 0; n < NUM_PRESCALERS; n++) begin
      dfull = DF_W'(prod_q[n]) << (BASE_SHIFT + 2 * n);
      dd    = dfull[D_W-1:0];
      pick_d.cands[n].ok  = ok_q[n];
      pick_d.cands[n].div = div_q[n];
      pick_d.cands[n].d   = dd;
      if (ck >= dd) begin
        pick_d.cands[n].mag = MAG_W'(ck - dd);
        pick_d.cands[n].neg = 1'b0;
      end else begin
        pick_d.cands[n].mag = MAG_W'(dd - ck);
        pick_d.cands[n].neg = 1'b1;
      end
    end
    // Seed the running best with the first prescaler
    pick_d.best.found = pick_d.cands[0].ok;
    pick_d.best.sel   = '0;
    if (pick_d.cands[0].ok) begin
      pick_d.best.div = pick_d.cands[0].div;
      pick_d.best.mag = pick_d.cands[0].mag;
      pick_d.best.d   = pick_d.cands[0].d;
      pick_d.best.neg = pick_d.cands[0].neg;
    end else begin
      pick_d.best.div = '0;
      pick_d.best.mag = '0;
      pick_d.best.d   = D_W'(1);
      pick_d.best.neg = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en_o) begin
        v1_q <= valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      ok_q   <= ok_d;
      div_q  <= div_d;
      prod_q <= prod_d;
    end
    if (en2) begin
      pick_q <= pick_d;
    end
  end

  assign valid_o = v2_q;
  assign data_o  = pick_q;
endmodule

// ===== sv/bds_pick_cell.sv =====
// Compare one prescaler against the running best: cross products, then update
module bds_pick_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bds_pkg::SEL_W-1:0]  sel_i,
  input  logic                       valid_i,
  input  bds_pkg::pick_t             data_i,
  input  logic                       en_i,
  output logic                       en_o,
  output logic                       valid_o,
  output bds_pkg::pick_t             data_o
);
  import bds_pkg::*;

  logic             va_q, vb_q, enb;
  pick_t            a_q, b_q, b_d;
  logic [CMP_W-1:0] pnew_q, pbest_q;
  cand_t            ci, ca;
  logic             take;

  assign enb  = !vb_q || en_i;
  assign en_o = !va_q || enb;
  assign ci   = data_i.cands[sel_i];
  assign ca   = a_q.cands[sel_i];

  always_comb begin
    take = ca.ok && (!a_q.best.found || (pnew_q < pbest_q));
    b_d  = a_q;
    if (take) begin
      b_d.best.found = 1'b1;
      b_d.best.sel   = sel_i;
      b_d.best.div   = ca.div;
      b_d.best.mag   = ca.mag;
      b_d.best.d     = ca.d;
      b_d.best.neg   = ca.neg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_o) begin
        va_q <= valid_i;
      end
      if (enb) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      a_q     <= data_i;
      pnew_q  <= CMP_W'(ci.mag) * CMP_W'(data_i.best.d);
      pbest_q <= CMP_W'(data_i.best.mag) * CMP_W'(ci.d);
    end
    if (enb) begin
      b_q <= b_d;
    end
  end

  assign valid_o = vb_q;
  assign data_o  = b_q;
endmodule

// ===== sv/baud_divisor_search.sv =====
// Top level of the baud divisor search
//
//   channel   dir  handshake      payload
//   in_i      in   valid/ready    bit_rate
//   out_o     out  valid/ready    usable, clock_select, divisor, error_hundredths
//   cfg       in   cfg_we_i       cfg_data_i (clock in Hz)
//
// One word is accepted every cycle unless the output stalls; stages at NUM_PRESCALERS = 4:
// 26 cells of the quotient divider, 2 candidate stages, 2 per extra prescaler in the
// compare chain, 1 scaling stage, 12 cells of the error divider and the output register.
// Every stage moves whenever its successor has room, so bubbles close up under a stall.
// Reset empties the pipeline and loads the clock register with 16 MHz.
`include "baud_divisor_search_macros.svh"

module baud_divisor_search (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bds_pkg::CLOCK_W-1:0] cfg_data_i,
  bds_in_if.sink                      in_i,
  bds_out_if.source                   out_o
);
  import bds_pkg::*;

  logic [CLOCK_W-1:0] clk_q;

  logic  dv_v  [0:X_W];
  logic  dv_en [0:X_W];
  div_t  dv_d  [0:X_W];

  logic  pk_v  [0:NUM_PRESCALERS-1];
  logic  pk_en [0:NUM_PRESCALERS-1];
  pick_t pk_d  [0:NUM_PRESCALERS-1];

  logic  ev_v  [0:ERR_Q_W];
  logic  ev_en [0:ERR_Q_W];
  div_t  ev_d  [0:ERR_Q_W];

  logic  num_v_q, num_en;
  div_t  num_q, num_d;

  logic                    out_v_q, out_en;
  logic                    usable_q;
  logic [SEL_W-1:0]        sel_q;
  logic [DIV_W-1:0]        div_q;
  logic signed [ERR_W-1:0] err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q <= CLOCK_RESET;
    end else if (cfg_we_i) begin
      clk_q <= cfg_data_i;
    end
  end

  // Quotient divider: clock / (16 * rate)
  assign dv_v[0]      = in_i.valid;
  assign dv_d[0].rem  = '0;
  assign dv_d[0].dvs  = REM_W'(in_i.bit_rate);
  assign dv_d[0].x    = clk_q[CLOCK_W-1:FRAC_W];
  assign dv_d[0].tag  = '0;
  assign in_i.ready   = dv_en[0];

  for (genvar i = 0; i < X_W; i++) begin : g_qdiv
    bds_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[i]),
      .data_i  (dv_d[i]),
      .en_i    (dv_en[i+1]),
      .en_o    (dv_en[i]),
      .valid_o (dv_v[i+1]),
      .data_o  (dv_d[i+1])
    );
  end

  bds_cand u_cand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clock_i (clk_q),
    .valid_i (dv_v[X_W]),
    .data_i  (dv_d[X_W]),
    .en_i    (pk_en[0]),
    .en_o    (dv_en[X_W]),
    .valid_o (pk_v[0]),
    .data_o  (pk_d[0])
  );

  for (genvar k = 1; k < NUM_PRESCALERS; k++) begin : g_pick
    bds_pick_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .sel_i   (SEL_W'(k)),
      .valid_i (pk_v[k-1]),
      .data_i  (pk_d[k-1]),
      .en_i    (pk_en[k]),
      .en_o    (pk_en[k-1]),
      .valid_o (pk_v[k]),
      .data_o  (pk_d[k])
    );
  end

  // Scale: (mag * 20000 + d) / (2 * d) rounds the error half away from zero
  always_comb begin
    logic [NUM_W-1:0] num;
    best_t            b;
    b   = pk_d[NUM_PRESCALERS-1].best;
    num = NUM_W'(b.mag) * NUM_W'(SCALE) + NUM_W'(b.d);
    num_d.rem       = num[NUM_W-1:ERR_Q_W];
    num_d.dvs       = {b.d, 1'b0};
    num_d.x         = {num[ERR_Q_W-1:0], {(X_W - ERR_Q_W){1'b0}}};
    num_d.tag.found = b.found;
    num_d.tag.sel   = b.sel;
    num_d.tag.div   = b.div;
    num_d.tag.neg   = b.neg;
  end

  assign num_en = !num_v_q || ev_en[0];
  assign pk_en[NUM_PRESCALERS-1] = num_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_v_q <= 1'b0;
    end else if (num_en) begin
      num_v_q <= pk_v[NUM_PRESCALERS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (num_en) begin
      num_q <= num_d;
    end
  end

  assign ev_v[0] = num_v_q;
  assign ev_d[0] = num_q;

  for (genvar j = 0; j < ERR_Q_W; j++) begin : g_ediv
    bds_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ev_v[j]),
      .data_i  (ev_d[j]),
      .en_i    (ev_en[j+1]),
      .en_o    (ev_en[j]),
      .valid_o (ev_v[j+1]),
      .data_o  (ev_d[j+1])
    );
  end

  // Output register; hold while the sink stalls
  assign out_en           = !out_v_q || out_o.ready;
  assign ev_en[ERR_Q_W]   = out_en;

  always_comb begin
    logic [ERR_W-1:0] h;
    h = ERR_W'(ev_d[ERR_Q_W].x[ERR_Q_W-1:0]);
    if (!ev_d[ERR_Q_W].tag.found) begin
      err_d = UNUSABLE_ERR;
    end else if (ev_d[ERR_Q_W].tag.neg) begin
      err_d = $signed(-h);
    end else begin
      err_d = $signed(h);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= ev_v[ERR_Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      usable_q <= ev_d[ERR_Q_W].tag.found;
      sel_q    <= ev_d[ERR_Q_W].tag.found ? ev_d[ERR_Q_W].tag.sel : '0;
      div_q    <= ev_d[ERR_Q_W].tag.found ? ev_d[ERR_Q_W].tag.div : '0;
      err_q    <= err_d;
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.usable           = usable_q;
  assign out_o.clock_select     = sel_q;
  assign out_o.divisor          = div_q;
  assign out_o.error_hundredths = err_q;

  `BDS_ASSERT(a_unusable_fields, out_o.valid && !out_o.usable, out_o.error_hundredths == UNUSABLE_ERR && out_o.divisor == '0 && out_o.clock_select == '0, "unusable word carries stray fields")
  `BDS_ASSERT(a_usable_range, out_o.valid && out_o.usable, out_o.divisor != '0 && $signed(out_o.error_hundredths) <= 15'sd2500 && $signed(out_o.error_hundredths) >= -15'sd2500, "usable word out of range")
  `BDS_ASSERT(a_ready_only_stall, !in_i.ready, out_o.valid && !out_o.ready, "input held off without an output stall")
  `BDS_ASSERT_NEXT(a_bubble_enters, in_i.ready && !in_i.valid, !dv_v[1], "bubble did not enter the divider")
endmodule
